/* hdl/lhe_pkg.sv */
// Shared types, constants and bin arithmetic for the latency histogram engine.
// Depends on nothing; used by lhe_ctrl, lhe_dpath and latency_histogram_engine.
package lhe_pkg;

	localparam int BINS_PER_GROUP = 128;
	localparam int COUNTER_WIDTH  = 32;
	localparam int GROUPS         = 5;
	localparam int NBINS          = GROUPS * BINS_PER_GROUP;
	localparam int ADDR_W         = $clog2(NBINS);
	localparam int IDX_W          = $clog2(BINS_PER_GROUP);
	localparam int GRP_W          = $clog2(GROUPS);

	localparam int OP_W     = 2;
	localparam int SAMPLE_W = 32;
	localparam int FRAC_W   = 16;
	localparam int TOTAL_W  = 48;
	localparam int SUM_W    = 60;
	localparam int EDGE_W   = 12;
	localparam int TERM_W   = COUNTER_WIDTH + EDGE_W;
	localparam int HALF_W   = TOTAL_W / 2;
	localparam int PROD_W   = FRAC_W + HALF_W;
	localparam int FULL_W   = FRAC_W + TOTAL_W;

	localparam int IN_W  = ((OP_W + SAMPLE_W + FRAC_W + 7) / 8) * 8;
	localparam int OUT_W = ((TOTAL_W + SUM_W + 3 * EDGE_W + 7) / 8) * 8;

	localparam logic [EDGE_W-1:0] OVF_EDGE = EDGE_W'(BINS_PER_GROUP * 31);

	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_REPORT = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_ADD_WR, ST_CLR, ST_WALK1, ST_DRAIN1, ST_DRAIN2,
		ST_FOLD, ST_MUL_LO, ST_MUL_HI, ST_WALK2, ST_DRAIN3, ST_DONE
	} state_t;

	typedef struct packed {
		logic load_in;
		logic cnt_clr;
		logic cnt_inc;
		logic mem_rd;
		logic rd_bin;
		logic walk;
		logic pass2;
		logic mem_clr;
		logic add_wr;
		logic acc_clr;
		logic fold;
		logic mul_lo;
		logic mul_hi;
		logic out_load;
	} lhe_cmd_t;

	typedef struct packed {
		logic cnt_last;
		logic out_busy;
	} lhe_sts_t;

	typedef struct packed {
		logic              ovf;
		logic [ADDR_W-1:0] idx;
	} bin_sel_t;

	function automatic logic [EDGE_W-1:0] bin_edge(input logic [ADDR_W-1:0] k);
		int g;
		int i;
		g = int'(k) / BINS_PER_GROUP;
		i = int'(k) % BINS_PER_GROUP;
		return EDGE_W'(BINS_PER_GROUP * ((1 << g) - 1) + (i << g));
	endfunction

	// group search over constant bounds; samples past the last group overflow
	function automatic bin_sel_t bin_of(input logic [SAMPLE_W-1:0] s);
		bin_sel_t r;
		logic     hit;
		r   = '{ovf: 1'b1, idx: '0};
		hit = 1'b0;
		for (int g = 0; g < GROUPS; g++) begin
			if (!hit && s < SAMPLE_W'(BINS_PER_GROUP * ((1 << (g + 1)) - 1))) begin
				hit   = 1'b1;
				r.ovf = 1'b0;
				r.idx = ADDR_W'(g * BINS_PER_GROUP)
					+ ADDR_W'((s - SAMPLE_W'(BINS_PER_GROUP * ((1 << g) - 1))) >> g);
			end
		end
		return r;
	endfunction

	function automatic logic [COUNTER_WIDTH-1:0] sat_inc(input logic [COUNTER_WIDTH-1:0] c);
		return (&c) ? c : c + COUNTER_WIDTH'(1);
	endfunction

endpackage

/* hdl/latency_histogram_engine.sv */
// Latency histogram engine: add: bin read, then saturating write-back.
// Clear: one bin per cycle. Report: the result follows two walks of the
// 640-bin memory at one read per cycle, drain, fold and a two-step multiply.
// Reset: asynchronous, active low; afterwards a clearing pass of the bin
// memory runs during which s_axis_tready stays low.
module latency_histogram_engine import lhe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// operation[1:0], sample[33:2], percentile_fraction[49:34], zero pad
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// total_count[47:0], sum_approx[107:48], min_value[119:108],
	// max_value[131:120], percentile_value[143:132]
	output logic [OUT_W-1:0] m_axis_tdata
);

	lhe_cmd_t           cmd;
	lhe_sts_t           sts;
	logic [TOTAL_W-1:0] total;
	logic [SUM_W-1:0]   sum;
	logic [EDGE_W-1:0]  min_v, max_v, perc_v;

	lhe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tdata[OP_W-1:0]),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lhe_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_sample (s_axis_tdata[OP_W +: SAMPLE_W]),
		.in_frac   (s_axis_tdata[OP_W + SAMPLE_W +: FRAC_W]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_total (total),
		.out_sum   (sum),
		.out_min   (min_v),
		.out_max   (max_v),
		.out_perc  (perc_v)
	);

	assign m_axis_tdata = OUT_W'({perc_v, max_v, min_v, sum, total});

endmodule

/* hdl/lhe_ctrl.sv */
// Sequencer for the latency histogram engine: add, clear, two-pass report.
// Depends on lhe_pkg; drives lhe_dpath through lhe_cmd_t.
module lhe_ctrl import lhe_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [OP_W-1:0] in_op,
	output logic            in_ready,
	input  lhe_sts_t        sts,
	output lhe_cmd_t        cmd
);

	state_t state_q, state_d;
	op_t    op;

	assign op = op_t'(in_op);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT, ST_CLR: begin
				if (sts.cnt_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (op)
						OP_ADD:    state_d = ST_ADD_WR;
						OP_CLEAR:  state_d = ST_CLR;
						OP_REPORT: state_d = ST_WALK1;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD_WR: state_d = ST_IDLE;
			ST_WALK1: begin
				if (sts.cnt_last) state_d = ST_DRAIN1;
			end
			ST_DRAIN1: state_d = ST_DRAIN2;
			ST_DRAIN2: state_d = ST_FOLD;
			ST_FOLD:   state_d = ST_MUL_LO;
			ST_MUL_LO: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_WALK2;
			ST_WALK2: begin
				if (sts.cnt_last) state_d = ST_DRAIN3;
			end
			ST_DRAIN3: state_d = ST_DONE;
			ST_DONE: begin
				if (!sts.out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_INIT, ST_CLR: begin
				cmd.mem_clr = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					cmd.cnt_clr = 1'b1;
					cmd.acc_clr = 1'b1;
					// issue the bin read in the transaction cycle
					if (op == OP_ADD) begin
						cmd.mem_rd = 1'b1;
						cmd.rd_bin = 1'b1;
					end
				end
			end
			ST_ADD_WR: cmd.add_wr = 1'b1;
			ST_WALK1: begin
				cmd.mem_rd  = 1'b1;
				cmd.walk    = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			ST_DRAIN1, ST_DRAIN2: ;
			ST_FOLD:   cmd.fold = 1'b1;
			ST_MUL_LO: cmd.mul_lo = 1'b1;
			ST_MUL_HI: begin
				cmd.mul_hi  = 1'b1;
				cmd.cnt_clr = 1'b1;
			end
			ST_WALK2: begin
				cmd.mem_rd  = 1'b1;
				cmd.walk    = 1'b1;
				cmd.pass2   = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			ST_DRAIN3: cmd.pass2 = 1'b1;
			ST_DONE: cmd.out_load = !sts.out_busy;
			default: ;
		endcase
	end

endmodule

/* hdl/lhe_dpath.sv */
// Datapath of the latency histogram engine: bin memory, overflow counter,
// report accumulators, threshold multiplier and result register. Uses lhe_pkg.
module lhe_dpath import lhe_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  lhe_cmd_t            cmd,
	output lhe_sts_t            sts,
	input  logic [SAMPLE_W-1:0] in_sample,
	input  logic [FRAC_W-1:0]   in_frac,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [TOTAL_W-1:0]  out_total,
	output logic [SUM_W-1:0]    out_sum,
	output logic [EDGE_W-1:0]   out_min,
	output logic [EDGE_W-1:0]   out_max,
	output logic [EDGE_W-1:0]   out_perc
);

	logic [COUNTER_WIDTH-1:0] mem_q [NBINS];
	logic [COUNTER_WIDTH-1:0] rd_data_s1;
	logic [ADDR_W-1:0]        addr_s1;
	logic                     valid_s1, valid_s2;
	logic [TERM_W-1:0]        term_s2;

	logic [ADDR_W-1:0]        cnt_q;
	logic [ADDR_W-1:0]        bin_q;
	logic                     ovf_sel_q;
	logic [FRAC_W-1:0]        frac_q;
	logic [COUNTER_WIDTH-1:0] ovf_cnt_q;

	logic [TOTAL_W-1:0] total_q, thres_q;
	logic [SUM_W-1:0]   sum_q;
	logic [EDGE_W-1:0]  min_q, max_q, perc_q;
	logic               seen_q, found_q;
	logic [PROD_W-1:0]  prod_lo_q;
	logic               out_valid_q;

	bin_sel_t           bin_in;
	logic [ADDR_W-1:0]  rd_addr;
	logic [EDGE_W-1:0]  edge_s1;
	logic [TERM_W-1:0]  term_s1, ovf_term;
	logic [PROD_W-1:0]  prod_hi;
	logic [FULL_W-1:0]  full_prod;
	logic [TOTAL_W-1:0] data_ext;

	assign bin_in    = bin_of(in_sample);
	assign rd_addr   = cmd.rd_bin ? bin_in.idx : cnt_q;
	assign edge_s1   = bin_edge(addr_s1);
	assign term_s1   = TERM_W'(rd_data_s1) * TERM_W'(edge_s1);
	assign ovf_term  = TERM_W'(ovf_cnt_q) * TERM_W'(OVF_EDGE);
	assign data_ext  = TOTAL_W'(rd_data_s1);
	assign prod_hi   = PROD_W'(frac_q) * PROD_W'(total_q[TOTAL_W-1:HALF_W]);
	assign full_prod = FULL_W'(prod_lo_q) + (FULL_W'(prod_hi) << HALF_W);

	assign sts.cnt_last = (cnt_q == ADDR_W'(NBINS - 1));
	assign sts.out_busy = out_valid_q && !out_ready;
	assign out_valid    = out_valid_q;

	// bin store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.mem_clr) begin
			mem_q[cnt_q] <= '0;
		end else if (cmd.add_wr && !ovf_sel_q) begin
			mem_q[bin_q] <= sat_inc(rd_data_s1);
		end
		if (cmd.mem_rd) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= cnt_q;
		term_s2 <= term_s1;
		if (cmd.load_in) begin
			bin_q     <= bin_in.idx;
			ovf_sel_q <= bin_in.ovf;
			frac_q    <= in_frac;
		end
		if (cmd.mul_lo) begin
			prod_lo_q <= PROD_W'(frac_q) * PROD_W'(total_q[HALF_W-1:0]);
		end
		if (cmd.out_load) begin
			out_total <= total_q;
			out_sum   <= sum_q;
			out_min   <= min_q;
			out_max   <= max_q;
			out_perc  <= perc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			ovf_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= cmd.mem_rd && cmd.walk;
			// the sum stage only serves the first walk
			valid_s2 <= valid_s1 && !cmd.pass2;
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + ADDR_W'(1);
			end
			if (cmd.mem_clr) begin
				ovf_cnt_q <= '0;
			end else if (cmd.add_wr && ovf_sel_q) begin
				ovf_cnt_q <= sat_inc(ovf_cnt_q);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// report accumulators
	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			total_q <= '0;
			sum_q   <= '0;
			min_q   <= OVF_EDGE;
			max_q   <= '0;
			perc_q  <= OVF_EDGE;
			seen_q  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			if (valid_s1 && !cmd.pass2) begin
				total_q <= total_q + data_ext;
				if (rd_data_s1 != '0) begin
					if (!seen_q) begin
						min_q  <= edge_s1;
						seen_q <= 1'b1;
					end
					max_q <= edge_s1;
				end
			end
			if (valid_s2 && !cmd.pass2) begin
				sum_q <= sum_q + SUM_W'(term_s2);
			end
			if (cmd.fold) begin
				total_q <= total_q + TOTAL_W'(ovf_cnt_q);
				sum_q   <= sum_q + SUM_W'(ovf_term);
				if (ovf_cnt_q != '0) max_q <= OVF_EDGE;
			end
			if (cmd.mul_hi) begin
				thres_q <= full_prod[FULL_W-1:FRAC_W];
			end
			// walk up the bins, taking each count off the threshold
			if (valid_s1 && cmd.pass2 && !found_q) begin
				if (thres_q < data_ext) begin
					perc_q  <= edge_s1;
					found_q <= 1'b1;
				end else begin
					thres_q <= thres_q - data_ext;
				end
			end
		end
	end

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("result register not marked valid after load");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && !out_ready))
		else $error("pending result overwritten");

	a_walk_not_add: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !cmd.add_wr)
		else $error("walk data overlaps an add write-back");

	a_clear_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_clr |-> !cmd.mem_rd && !cmd.add_wr)
		else $error("clear sweep collides with another access");

endmodule

/* sim/latency_histogram_engine_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for latency_histogram_engine: a behavioural histogram predicts each
// statistics report. Depends on lhe_pkg and the engine RTL only.
module latency_histogram_engine_tb;
	import lhe_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             s_axis_tvalid;
	logic             s_axis_tready;
	// operation, sample, percentile_fraction, zero pad
	logic [IN_W-1:0]  s_axis_tdata;
	logic             m_axis_tvalid;
	logic             m_axis_tready;
	// total_count, sum_approx, min_value, max_value, percentile_value
	logic [OUT_W-1:0] m_axis_tdata;

	typedef struct packed {
		logic [EDGE_W-1:0]  pct;
		logic [EDGE_W-1:0]  maxv;
		logic [EDGE_W-1:0]  minv;
		logic [SUM_W-1:0]   sum;
		logic [TOTAL_W-1:0] total;
	} stats_t;

	localparam logic [63:0] CNT_FULL = 64'hFFFF_FFFF;
	localparam logic [63:0] TOT_FULL = (64'd1 << TOTAL_W) - 1;
	localparam logic [63:0] SUM_FULL = (64'd1 << SUM_W) - 1;
	localparam logic [1:0]  OP_UNUSED = 2'd3;

	logic [63:0] hist_bins [NBINS];
	logic [63:0] hist_ovf;
	stats_t      stats_pending [$];
	int          mismatches;
	int          reports_seen;
	int          rx_gap;
	bit          tx_idle_en;
	bit          rx_idle_en;
	bit          rx_hold;

	latency_histogram_engine uut (.*);

	always #2 clk = ~clk;

	function automatic logic [63:0] edge_of(int k);
		int g;
		g = k / BINS_PER_GROUP;
		return 64'(BINS_PER_GROUP * ((1 << g) - 1) + ((k % BINS_PER_GROUP) << g));
	endfunction

	function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
		if (a > lim) a = lim;
		if (b > lim - a) return lim;
		return a + b;
	endfunction

	function automatic logic [63:0] term_sat(logic [63:0] c, logic [63:0] e);
		if (e != 0 && c > SUM_FULL / e) return SUM_FULL;
		return c * e;
	endfunction

	function automatic void clear_hist();
		foreach (hist_bins[k]) hist_bins[k] = 0;
		hist_ovf = 0;
	endfunction

	function automatic void record_sample(logic [31:0] s);
		logic [63:0] base;
		int k;
		for (int g = 0; g < GROUPS; g++) begin
			base = 64'(BINS_PER_GROUP * ((1 << g) - 1));
			if (64'(s) < 64'(BINS_PER_GROUP * ((1 << (g + 1)) - 1))) begin
				k = g * BINS_PER_GROUP + int'((64'(s) - base) >> g);
				if (hist_bins[k] < CNT_FULL) hist_bins[k]++;
				return;
			end
		end
		if (hist_ovf < CNT_FULL) hist_ovf++;
	endfunction

	function automatic stats_t summarise(logic [15:0] p);
		stats_t r;
		logic [63:0] tot, sum, mn, mx, pc, th;
		bit seen, found;
		tot = 0; sum = 0; mn = 64'(OVF_EDGE); mx = 0; pc = 64'(OVF_EDGE);
		seen = 0; found = 0;
		for (int k = 0; k < NBINS; k++) begin
			tot = add_sat(tot, hist_bins[k], TOT_FULL);
			sum = add_sat(sum, term_sat(hist_bins[k], edge_of(k)), SUM_FULL);
			if (hist_bins[k] != 0) begin
				if (!seen) mn = edge_of(k);
				seen = 1;
				mx = edge_of(k);
			end
		end
		tot = add_sat(tot, hist_ovf, TOT_FULL);
		sum = add_sat(sum, term_sat(hist_ovf, 64'(OVF_EDGE)), SUM_FULL);
		if (hist_ovf != 0) mx = 64'(OVF_EDGE);
		// total is below 2^48, so the product fits in 64 bits
		th = (64'(p) * tot) >> 16;
		for (int k = 0; k < NBINS && !found; k++) begin
			if (th < hist_bins[k]) begin
				pc = edge_of(k);
				found = 1;
			end else begin
				th -= hist_bins[k];
			end
		end
		r.total = tot[TOTAL_W-1:0];
		r.sum   = sum[SUM_W-1:0];
		r.minv  = mn[EDGE_W-1:0];
		r.maxv  = mx[EDGE_W-1:0];
		r.pct   = pc[EDGE_W-1:0];
		return r;
	endfunction

	// drop tvalid once no further transaction follows straight away
	task automatic tx_stop();
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic send_op(logic [1:0] op, logic [31:0] s = 0, logic [15:0] p = 0);
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_W'({p, s, op});
		do @(posedge clk); while (!s_axis_tready);
		case (op)
			OP_ADD:    record_sample(s);
			OP_CLEAR:  clear_hist();
			OP_REPORT: stats_pending.push_back(summarise(p));
			default:   ;
		endcase
	endtask

	task automatic wait_drained();
		tx_stop();
		while (stats_pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(0, 7))
			0:       return $urandom;
			1:       return $urandom_range(3960, 4100);
			2:       return $urandom_range(0, 130);
			default: return $urandom_range(0, 4000);
		endcase
	endfunction

	// receive side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_gap        <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				stats_t got, exp;
				got = stats_t'(m_axis_tdata[TOTAL_W+SUM_W+3*EDGE_W-1:0]);
				reports_seen++;
				if (stats_pending.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected report %h", got);
				end else begin
					exp = stats_pending.pop_front();
					if (got !== exp) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("report mismatch: exp total %0d sum %0d min %0d max %0d pct %0d",
								exp.total, exp.sum, exp.minv, exp.maxv, exp.pct);
							$display("                 got total %0d sum %0d min %0d max %0d pct %0d",
								got.total, got.sum, got.minv, got.maxv, got.pct);
						end
					end
				end
			end
			// idle in bursts of random length
			if (rx_gap != 0) begin
				rx_gap        <= rx_gap - 1;
				m_axis_tready <= 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
				rx_gap        <= $urandom_range(0, 3);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= !rx_hold;
			end
		end
	end

	task automatic test_empty_and_edges();
		send_op(OP_REPORT, 0, 16'hFFFF);
		send_op(OP_ADD, 32'd0);
		send_op(OP_ADD, 32'd127);
		send_op(OP_ADD, 32'd128);
		send_op(OP_ADD, 32'd383);
		send_op(OP_ADD, 32'd384);
		send_op(OP_ADD, 32'd895);
		send_op(OP_ADD, 32'd896);
		send_op(OP_ADD, 32'd1919);
		send_op(OP_ADD, 32'd1920);
		send_op(OP_ADD, 32'd3967);
		send_op(OP_ADD, 32'd3968);
		send_op(OP_ADD, 32'hFFFF_FFFF);
		send_op(OP_UNUSED, 32'd5, 16'd7);
		send_op(OP_REPORT, 0, 16'd0);
		send_op(OP_REPORT, 0, 16'hFFFF);
		send_op(OP_REPORT, 0, 16'h8000);
		send_op(OP_CLEAR, 32'hFFFF_FFFF, 16'hFFFF);
		send_op(OP_ADD, 32'd3000);
		send_op(OP_REPORT, 0, 16'h4000);
		send_op(OP_CLEAR);
		send_op(OP_REPORT, 32'hFFFF_FFFF, 16'h1234);
	endtask

	task automatic test_backpressure();
		rx_hold = 1;
		fork
			begin
				send_op(OP_ADD, 32'd50);
				send_op(OP_REPORT, 0, 16'h8000);
				send_op(OP_REPORT, 0, 16'h0100);
				send_op(OP_ADD, 32'd60);
				send_op(OP_REPORT, 0, 16'hC000);
				tx_stop();
			end
			begin
				repeat (6000) @(posedge clk);
				rx_hold = 0;
			end
		join
		@(posedge clk);
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			int r;
			r = $urandom_range(0, 99);
			if (r < 88) send_op(OP_ADD, rand_sample(), 16'($urandom));
			else if (r < 96) send_op(OP_REPORT, $urandom, 16'($urandom));
			else if (r < 98) send_op(OP_CLEAR, $urandom, 16'($urandom));
			else send_op(OP_UNUSED, $urandom, 16'($urandom));
		end
		send_op(OP_REPORT, 0, 16'($urandom));
	endtask

	initial begin
		clk = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		mismatches = 0;
		reports_seen = 0;
		rx_hold = 0;
		tx_idle_en = 1;
		rx_idle_en = 1;
		clear_hist();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_and_edges();
		test_backpressure();
		test_random(420);
		tx_idle_en = 0;
		rx_idle_en = 0;
		test_random(110);
		wait_drained();
		$display("Covered bin edges, overflow, clear, unused code, long output stall");
		$display("and %0d reports.", reports_seen);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("timeout, %0d reports outstanding", stats_pending.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule

/* files.f */
hdl/lhe_pkg.sv
hdl/lhe_ctrl.sv
hdl/lhe_dpath.sv
hdl/latency_histogram_engine.sv
sim/latency_histogram_engine_tb.sv
